@@ hw/rtl/running_median_filter_macros.svh @@
// Assertion macros for the running median filter.
// Included by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef RUNNING_MEDIAN_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define RMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("running median filter check failed");
// Next-cycle implication, checked while out of reset.
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("running median filter check failed");
`else
`define RMF_ASSERT_NOW(lbl, ante, cons)
`define RMF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/rmf_pkg.sv @@
// Shared constants and link types for the running median filter.
// No dependencies; used by rmf_cell and running_median_filter.
package rmf_pkg;

    localparam int WINDOW      = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int AGE_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_BITS    = AGE_BITS;
    localparam int CNT_BITS    = $clog2(WINDOW + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_value;
    typedef logic [AGE_BITS-1:0]           t_age;
    typedef logic [CNT_BITS-1:0]           t_count;

    localparam t_age AGE_OLDEST = t_age'(WINDOW - 1);

    // Travels from a cell to its right neighbor (toward smaller values).
    typedef struct packed {
        logic   valid;      // this cell holds a sample
        logic   evicted;    // the oldest sample sits at or left of this cell
        logic   ge_kept;    // kept sample at this rank is >= the new sample
        t_value kept_value; // sample at this rank once the oldest is dropped
        t_age   kept_age;
    } t_fwd;

    // Travels from a cell to its left neighbor.
    typedef struct packed {
        logic   ge;         // this cell holds a sample >= the new sample
        t_value value;
        t_age   age;
    } t_bwd;

endpackage

@@ hw/rtl/rmf_cell.sv @@
// One slot of the sorted window: holds a sample, its age and a valid bit.
// Depends on rmf_pkg; instantiated in a row by running_median_filter.
module rmf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  rmf_pkg::t_value i_sample,
    input  rmf_pkg::t_fwd   i_fwd,
    input  rmf_pkg::t_bwd   i_bwd,
    output rmf_pkg::t_fwd   o_fwd,
    output rmf_pkg::t_bwd   o_bwd
);
    import rmf_pkg::*;

    logic   r_valid;
    t_value r_value;
    t_age   r_age;
    logic   n_valid;
    t_value n_value;
    t_age   n_age;

    logic   w_ge;
    logic   w_evicted;

    assign w_ge      = r_valid && (r_value >= i_sample);
    assign w_evicted = i_fwd.evicted || (r_valid && (r_age == AGE_OLDEST));

    // Once the oldest sample is at or left of this slot, the kept list is one slot ahead.
    always_comb begin
        o_fwd.valid      = r_valid;
        o_fwd.evicted    = w_evicted;
        o_fwd.ge_kept    = w_evicted ? i_bwd.ge : w_ge;
        o_fwd.kept_value = w_evicted ? i_bwd.value : r_value;
        o_fwd.kept_age   = w_evicted ? i_bwd.age : r_age;
    end

    assign o_bwd.ge    = w_ge;
    assign o_bwd.value = r_value;
    assign o_bwd.age   = r_age;

    // The new sample lands just behind the last kept sample that is >= it.
    always_comb begin
        n_valid = r_valid || i_fwd.valid;
        if (o_fwd.ge_kept) begin
            n_value = o_fwd.kept_value;
            n_age   = o_fwd.kept_age + 1'b1;
        end else if (i_fwd.ge_kept) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = i_fwd.kept_value;
            n_age   = i_fwd.kept_age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

@@ hw/rtl/running_median_filter.sv @@
// Channel  | valid           | ready           | payload
// ---------+-----------------+-----------------+----------------------------
// input    | i_sample_valid  | o_sample_ready  | i_sample (signed)
// output   | o_median_valid  | i_median_ready  | o_median_value (signed)
//
// One sample per cycle is taken while o_sample_ready is high; the row of cells updates in the transfer cycle.
// The transfer edge loads the cells and sets the pending flag; the selected rank is then loaded into
// the output register, which raises o_median_valid, once that register is free.
// Synchronous active-low reset empties the window; no clearing pass is needed.
// A stalled output holds one result and one more waits in the cells before input stalls.
// Top level of the running median filter; depends on rmf_pkg, rmf_cell and the macros header.
`include "running_median_filter_macros.svh"
module running_median_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sample_valid,
    output logic            o_sample_ready,
    input  rmf_pkg::t_value i_sample,
    output logic            o_median_valid,
    input  logic            i_median_ready,
    output rmf_pkg::t_value o_median_value
);
    import rmf_pkg::*;

    t_fwd   w_fwd [WINDOW+1];
    t_bwd   w_bwd [WINDOW+1];
    t_value w_vals [WINDOW];
    logic [WINDOW-1:0] w_valid_vec;

    logic   w_load;
    logic   w_out_free;
    t_count r_count;
    t_count n_count;
    t_count w_mid_pos;
    logic   r_mid_valid;
    logic   r_out_valid;
    t_value r_median;

    assign w_out_free     = !r_out_valid || i_median_ready;
    assign o_sample_ready = !r_mid_valid || w_out_free;
    assign w_load         = i_sample_valid && o_sample_ready;

    // Left end: nothing evicted yet, and the new sample may take slot zero.
    assign w_fwd[0] = '{valid: 1'b1, evicted: 1'b0, ge_kept: 1'b1,
                        kept_value: '0, kept_age: '0};
    assign w_bwd[WINDOW] = '{ge: 1'b0, value: '0, age: '0};

    for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
        rmf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_load),
            .i_sample (i_sample),
            .i_fwd    (w_fwd[gi]),
            .i_bwd    (w_bwd[gi+1]),
            .o_fwd    (w_fwd[gi+1]),
            .o_bwd    (w_bwd[gi])
        );
        assign w_vals[gi]      = w_bwd[gi].value;
        assign w_valid_vec[gi] = w_fwd[gi+1].valid;
    end

    // The last cell's valid bit says the window is full.
    assign n_count   = r_count + t_count'(!w_fwd[WINDOW].valid);
    assign w_mid_pos = (r_count - 1'b1) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_mid_valid <= 1'b1;
            end else if (w_out_free) begin
                r_mid_valid <= 1'b0;
            end
            if (r_mid_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_median_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mid_valid && w_out_free) begin
            r_median <= w_vals[w_mid_pos[IDX_BITS-1:0]];
        end
    end

    assign o_median_valid = r_out_valid;
    assign o_median_value = r_median;

    `RMF_ASSERT_NOW(a_count_range, 1'b1, r_count <= t_count'(WINDOW))
    `RMF_ASSERT_NOW(a_valid_matches_count, 1'b1, $countones(w_valid_vec) == r_count)
    `RMF_ASSERT_NEXT(a_load_gives_result, w_load, r_mid_valid && (r_count != '0))
    `RMF_ASSERT_NOW(a_no_overrun, r_mid_valid && !w_out_free, !o_sample_ready)

endmodule
